// ===== rtl/core/mff_pkg.sv =====
// Shared types and constants for the message fragmenting framer.
// No dependencies.
package mff_pkg;

   localparam int LEN_W  = 7;   // message length / byte counter width
   localparam int POS_W  = 6;   // frame position and padding count width
   localparam int BYTE_W = 8;
   localparam int TYPE_W = 2;

   // What one accepted request turns into, handed from planner to emitter
   typedef struct packed {
      logic              err;         // emit one error result only
      logic              hdr_pend;    // a header byte goes out before the data
      logic [BYTE_W-1:0] hdr;
      logic [BYTE_W-1:0] data;
      logic              data_flast;
      logic              data_mlast;
      logic [POS_W-1:0]  pad_cnt;     // zero bytes that follow the data
   } plan_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_ERR  = 5'b00010,
      PH_HDR  = 5'b00100,
      PH_DATA = 5'b01000,
      PH_PAD  = 5'b10000
   } phase_type;

endpackage

// ===== rtl/core/mff_plan.sv =====
// Message state (bytes taken, frame position, drop flag) and the per-request plan.
// Depends on mff_pkg.
module mff_plan import mff_pkg::*; #(
   parameter int FRAME_DATA_BYTES  = 16,
   parameter int MAX_MESSAGE_BYTES = 124
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [LEN_W-1:0]  msg_length,
   input  logic [TYPE_W-1:0] msg_type,
   output plan_type          plan,
   output logic              plan_has_results
);

   localparam logic [POS_W-1:0] FrameBytes = POS_W'(FRAME_DATA_BYTES);
   localparam logic [LEN_W-1:0] MaxBytes   = LEN_W'(MAX_MESSAGE_BYTES);

   logic [LEN_W-1:0] bytes_taken_ff, bytes_taken_in;
   logic [POS_W-1:0] frame_pos_ff, frame_pos_in;
   logic             dropping_ff, dropping_in;

   logic             first, drop, msg_end, full, final_frame;
   logic [POS_W-1:0] fp0, fp1;
   logic [LEN_W:0]   taken_inc, len_sum;

   always_comb begin
      first     = (bytes_taken_ff == '0);
      fp0       = first ? '0 : frame_pos_ff;
      drop      = first ? (msg_length == '0 || msg_length > MaxBytes) : dropping_ff;
      taken_inc = {1'b0, bytes_taken_ff} + (LEN_W+1)'(1);
      msg_end   = (taken_inc >= {1'b0, msg_length});
      fp1       = fp0 + POS_W'(1);
      full      = (fp1 >= FrameBytes);
      // word count = ceil(len/4), kept to header bits 6:2
      len_sum   = {1'b0, msg_length} + (LEN_W+1)'(3);
      final_frame = ({1'b0, msg_length}
                     <= {1'b0, bytes_taken_ff} + (LEN_W+1)'(FrameBytes));

      plan.err        = first && drop;
      plan.hdr_pend   = !drop && (fp0 == '0);
      plan.hdr        = {final_frame, len_sum[6:2], msg_type};
      plan.data       = data_byte;
      plan.data_flast = full;
      plan.data_mlast = msg_end && full;
      plan.pad_cnt    = (msg_end && !full) ? (FrameBytes - fp1) : '0;
      plan_has_results = !drop || first;

      if (msg_end) begin
         bytes_taken_in = '0;
         frame_pos_in   = '0;
         dropping_in    = 1'b0;
      end else begin
         bytes_taken_in = taken_inc[LEN_W-1:0];
         if (drop) begin
            frame_pos_in = fp0;
         end else if (full) begin
            frame_pos_in = '0;
         end else begin
            frame_pos_in = fp1;
         end
         dropping_in = drop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_taken_ff <= '0;
         frame_pos_ff   <= '0;
         dropping_ff    <= 1'b0;
      end else if (take) begin
         bytes_taken_ff <= bytes_taken_in;
         frame_pos_ff   <= frame_pos_in;
         dropping_ff    <= dropping_in;
      end
   end

endmodule

// ===== rtl/core/mff_emit.sv =====
// Work reg and result reg: walks a request's plan out one byte per unstalled cycle.
// Depends on mff_pkg.
module mff_emit import mff_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  plan_type          plan,
   output logic              load_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_frame_byte,
   output logic              rsp_frame_last,
   output logic              rsp_message_last,
   output logic              rsp_status,
   output logic              rsp_run_last
);

   phase_type         phase_ff, phase_in;
   plan_type          work_ff, work_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              flast_ff, flast_in;
   logic              mlast_ff, mlast_in;
   logic              status_ff, status_in;
   logic              rlast_ff, rlast_in;

   logic              out_free, emit, res_last, pad_one;
   logic [BYTE_W-1:0] res_byte;
   logic              res_flast, res_mlast, res_status;
   phase_type         phase_next;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = (phase_ff != PH_IDLE) && out_free;
      pad_one  = (work_ff.pad_cnt == POS_W'(1));

      res_byte   = '0;
      res_flast  = 1'b0;
      res_mlast  = 1'b0;
      res_status = 1'b0;
      res_last   = 1'b0;
      phase_next = PH_IDLE;
      case (phase_ff)
         PH_ERR: begin
            res_status = 1'b1;
            res_last   = 1'b1;
         end
         PH_HDR: begin
            res_byte   = work_ff.hdr;
            phase_next = PH_DATA;
         end
         PH_DATA: begin
            res_byte  = work_ff.data;
            res_flast = work_ff.data_flast;
            res_mlast = work_ff.data_mlast;
            res_last  = (work_ff.pad_cnt == '0);
            phase_next = res_last ? PH_IDLE : PH_PAD;
         end
         PH_PAD: begin
            res_flast  = pad_one;
            res_mlast  = pad_one;
            res_last   = pad_one;
            phase_next = pad_one ? PH_IDLE : PH_PAD;
         end
         default: begin
            phase_next = PH_IDLE;
         end
      endcase

      load_ready = (phase_ff == PH_IDLE) || (emit && res_last);

      phase_in = phase_ff;
      work_in  = work_ff;
      if (load) begin
         work_in = plan;
         if (plan.err) begin
            phase_in = PH_ERR;
         end else if (plan.hdr_pend) begin
            phase_in = PH_HDR;
         end else begin
            phase_in = PH_DATA;
         end
      end else if (emit) begin
         phase_in = phase_next;
         if (phase_ff == PH_PAD) begin
            work_in.pad_cnt = work_ff.pad_cnt - POS_W'(1);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      byte_in   = byte_ff;
      flast_in  = flast_ff;
      mlast_in  = mlast_ff;
      status_in = status_ff;
      rlast_in  = rlast_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in   = res_byte;
         flast_in  = res_flast;
         mlast_in  = res_mlast;
         status_in = res_status;
         rlast_in  = res_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      byte_ff   <= byte_in;
      flast_ff  <= flast_in;
      mlast_ff  <= mlast_in;
      status_ff <= status_in;
      rlast_ff  <= rlast_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = byte_ff;
   assign rsp_frame_last   = flast_ff;
   assign rsp_message_last = mlast_ff;
   assign rsp_status       = status_ff;
   assign rsp_run_last     = rlast_ff;

endmodule

// ===== rtl/core/message_fragmenting_framer.sv =====
// Message fragmenting framer: request channel in, framed byte stream out.
// Request: one payload byte with its message length and type. Results: header,
// data and zero padding bytes, or a single error result (status 1) for a message
// of length zero or longer than MAX_MESSAGE_BYTES, whose bytes are then dropped.
// A request moves at an edge with req_valid high and req_stall low; a result
// moves likewise on rsp_valid / rsp_stall.
// A request's first result goes through the work register, then the result register.
// Throughput: one result per cycle while the receiver does not stall. A request
// holds the request channel until its last result goes out (a plain data byte
// yields 1 result, with header 2, and the final byte of a message up to
// FRAME_DATA_BYTES - 1 padding results more); dropped bytes after the first
// yield nothing. The single result register sets the rate, one byte per cycle.
// Reset clears message state and empties both registers; no result is pending.
// While the receiver stalls, the result register holds and the work register
// waits behind it; req_stall rises once the current request still has bytes to send.
// Depends on mff_pkg, mff_plan, mff_emit.
module message_fragmenting_framer import mff_pkg::*; #(
   parameter int FRAME_DATA_BYTES  = 16,
   parameter int MAX_MESSAGE_BYTES = 124
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [LEN_W-1:0]  req_msg_length,
   input  logic [TYPE_W-1:0] req_msg_type,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_frame_byte,
   output logic              rsp_frame_last,
   output logic              rsp_message_last,
   output logic              rsp_status,
   output logic              rsp_run_last
);

   plan_type plan;
   logic     plan_has_results;
   logic     load_ready;
   logic     accept;

   assign req_stall = !load_ready;
   assign accept    = req_valid && load_ready;

   mff_plan #(
      .FRAME_DATA_BYTES  (FRAME_DATA_BYTES),
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_plan (
      .clock            (clock),
      .reset            (reset),
      .take             (accept),
      .data_byte        (req_data_byte),
      .msg_length       (req_msg_length),
      .msg_type         (req_msg_type),
      .plan             (plan),
      .plan_has_results (plan_has_results)
   );

   mff_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load             (accept && plan_has_results),
      .plan             (plan),
      .load_ready       (load_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_message_last (rsp_message_last),
      .rsp_status       (rsp_status),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for message_fragmenting_framer.
// Predicts header, data, padding and error bytes per request and checks every output byte.
// Depends on mff_pkg and the framer RTL.
module tb import mff_pkg::*; ();

   localparam int CLK_PERIOD  = 12;
   localparam int FRAME_BYTES = 16;
   localparam int MAX_BYTES   = 124;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 40;

   localparam logic [BYTE_W-1:0] HDR_FINAL      = 8'h80;
   localparam logic [BYTE_W-1:0] HDR_WORDS_MASK = 8'h7C;
   localparam logic [BYTE_W-1:0] HDR_TYPE_MASK  = 8'h03;
   localparam logic              STAT_OK        = 1'b0;
   localparam logic              STAT_DROPPED   = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] fbyte;
      logic              flast;
      logic              mlast;
      logic              status;
      logic              rlast;
   } frame_out_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_data_byte;
   logic [LEN_W-1:0]  req_msg_length;
   logic [TYPE_W-1:0] req_msg_type;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [BYTE_W-1:0] rsp_frame_byte;
   logic              rsp_frame_last;
   logic              rsp_message_last;
   logic              rsp_status;
   logic              rsp_run_last;

   // predictor state
   int            taken_cnt;
   int            fill_pos;
   bit            drop_msg;
   frame_out_type frames_due[$];

   int  tx_idle_pct;
   int  rx_stall_pct;
   logic hold_rx;
   int  errors;
   int  reqs_sent;
   int  reqs_framed;
   int  msgs_sent;
   int  bytes_checked;
   int  drops_seen;

   message_fragmenting_framer #(
      .FRAME_DATA_BYTES  (FRAME_BYTES),
      .MAX_MESSAGE_BYTES (MAX_BYTES)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_msg_length   (req_msg_length),
      .req_msg_type     (req_msg_type),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_message_last (rsp_message_last),
      .rsp_status       (rsp_status),
      .rsp_run_last     (rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * 400000);
      $display("CHECKS FAILED");
      $finish;
   end

   // Works out the output bytes of one accepted request and queues them.
   function automatic int frame_request(logic [BYTE_W-1:0] d, logic [LEN_W-1:0] len_in,
                                        logic [TYPE_W-1:0] typ);
      frame_out_type run[$];
      int         len;
      int         words;
      bit         msg_end;
      bit         full;
      logic [BYTE_W-1:0] hdr;
      len = len_in;
      if (taken_cnt == 0) begin
         fill_pos = 0;
         drop_msg = (len == 0 || len > MAX_BYTES);
         if (drop_msg)
            run.push_back('{8'h00, 1'b0, 1'b0, STAT_DROPPED, 1'b0});
      end
      msg_end = (taken_cnt + 1 >= len);
      if (!drop_msg) begin
         if (fill_pos == 0) begin
            words = (len + 3) / 4;
            hdr = BYTE_W'(((words << 2) & HDR_WORDS_MASK) | (typ & HDR_TYPE_MASK));
            // final frame flag comes from this byte's length
            if (len <= taken_cnt + FRAME_BYTES)
               hdr = hdr | HDR_FINAL;
            run.push_back('{hdr, 1'b0, 1'b0, STAT_OK, 1'b0});
         end
         fill_pos++;
         if (msg_end) begin
            full = (fill_pos >= FRAME_BYTES);
            run.push_back('{d, full, full, STAT_OK, 1'b0});
            while (fill_pos < FRAME_BYTES) begin
               fill_pos++;
               full = (fill_pos >= FRAME_BYTES);
               run.push_back('{8'h00, full, full, STAT_OK, 1'b0});
            end
         end else begin
            full = (fill_pos >= FRAME_BYTES);
            run.push_back('{d, full, 1'b0, STAT_OK, 1'b0});
            if (full)
               fill_pos = 0;
         end
      end
      if (msg_end) begin
         taken_cnt = 0;
         fill_pos  = 0;
         drop_msg  = 1'b0;
      end else begin
         taken_cnt = (taken_cnt + 1) & 8'h7F;
         fill_pos  = fill_pos & 8'h3F;
      end
      if (run.size() > 0)
         run[run.size() - 1].rlast = 1'b1;
      foreach (run[i])
         frames_due.push_back(run[i]);
      return run.size();
   endfunction

   task automatic send_req(input logic [BYTE_W-1:0] d, input logic [LEN_W-1:0] len,
                           input logic [TYPE_W-1:0] typ);
      int n;
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= d;
      req_msg_length <= len;
      req_msg_type   <= typ;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      n = frame_request(d, len, typ);
      reqs_sent++;
      if (n > 0)
         reqs_framed++;
   endtask

   // Sends one message; with warp_pct > 0 the length may change on any byte.
   task automatic send_message(input int len, input logic [TYPE_W-1:0] typ, input int warp_pct);
      logic [LEN_W-1:0] cur;
      msgs_sent++;
      do begin
         cur = LEN_W'(len);
         if (warp_pct > 0 && $urandom_range(99) < warp_pct)
            cur = LEN_W'($urandom_range(127));
         send_req(BYTE_W'($urandom_range(255)), cur, typ);
      end while (taken_cnt != 0);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 45)
         return $urandom_range(1, 20);
      else if (r < 65) begin
         case ($urandom_range(7))
            0: return FRAME_BYTES - 1;
            1: return FRAME_BYTES;
            2: return FRAME_BYTES + 1;
            3: return 2 * FRAME_BYTES;
            4: return 2 * FRAME_BYTES + 1;
            5: return 3 * FRAME_BYTES;
            6: return 1;
            default: return MAX_BYTES;
         endcase
      end else if (r < 90)
         return $urandom_range(1, MAX_BYTES);
      else if (r < 95)
         return 0;
      else
         return $urandom_range(MAX_BYTES + 1, 127);
   endfunction

   task automatic test_directed();
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      msgs_sent++;
      send_req(8'hFF, 7'd1, 2'd0);        // one byte, rest of the frame padding
      msgs_sent++;
      send_req(8'h00, 7'd0, 2'd3);        // zero length is rejected
      msgs_sent++;
      send_req(8'hAA, 7'd127, 2'd2);      // too long: error, then dropped
      send_req(8'h55, 7'd2, 2'd2);        // shrinks, ends the dropped message
      msgs_sent++;
      send_req(8'h00, 7'd3, 2'd3);
      send_req(8'h80, 7'd3, 2'd3);
      send_req(8'h7F, 7'd3, 2'd3);
      // second frame header sees length 127: word count masks to zero
      msgs_sent++;
      for (int i = 0; i < 16; i++)
         send_req(BYTE_W'(i * 17), 7'd17, 2'd1);
      send_req(8'hC3, 7'd127, 2'd1);
      send_req(8'h3C, 7'd18, 2'd1);
   endtask

   task automatic test_random_phase(input int tx_pct, input int rx_pct, input int count);
      int goal;
      tx_idle_pct = tx_pct;
      rx_stall_pct <= rx_pct;
      goal = reqs_sent + count;
      while (reqs_sent < goal) begin
         if ($urandom_range(99) < 80)
            send_message(pick_length(), TYPE_W'($urandom_range(3)), 0);
         else
            send_message($urandom_range(1, MAX_BYTES), TYPE_W'($urandom_range(3)), 25);
      end
   endtask

   // Receiver holds off while the sender keeps offering, so the framer fills and stalls.
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      fork
         begin
            hold_rx <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rx <= 1'b0;
         end
         send_message(40, 2'd2, 0);
      join
   endtask

   always @(posedge clock) begin
      if (hold_rx)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < rx_stall_pct);
   end

   always @(posedge clock) begin
      frame_out_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         bytes_checked++;
         if (rsp_status === STAT_DROPPED)
            drops_seen++;
         if (frames_due.size() == 0) begin
            errors++;
            if (errors < 40)
               $display("%0t: unexpected output byte %h status %b", $time,
                        rsp_frame_byte, rsp_status);
         end else begin
            want = frames_due.pop_front();
            if (rsp_frame_byte !== want.fbyte || rsp_frame_last !== want.flast ||
                rsp_message_last !== want.mlast || rsp_status !== want.status ||
                rsp_run_last !== want.rlast) begin
               errors++;
               if (errors < 40)
                  $display("%0t: mismatch exp %h fl/ml/st/rl %b%b%b%b got %h %b%b%b%b",
                           $time, want.fbyte, want.flast, want.mlast, want.status,
                           want.rlast, rsp_frame_byte, rsp_frame_last, rsp_message_last,
                           rsp_status, rsp_run_last);
            end
         end
      end
   end

   initial begin
      int waited;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_msg_length = '0;
      req_msg_type   = '0;
      rsp_stall      = 1'b0;
      hold_rx        = 1'b0;
      tx_idle_pct    = 0;
      rx_stall_pct   = 0;
      errors         = 0;
      reqs_sent      = 0;
      reqs_framed    = 0;
      msgs_sent      = 0;
      bytes_checked  = 0;
      drops_seen     = 0;
      taken_cnt      = 0;
      fill_pos       = 0;
      drop_msg       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_phase(0, 0, 50);
      test_random_phase(61, 0, 50);
      test_backpressure();
      test_random_phase(0, 61, 50);
      test_random_phase(29, 29, 50);
      req_valid <= 1'b0;
      rx_stall_pct <= 0;

      waited = 0;
      while (frames_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (frames_due.size() != 0) begin
         errors++;
         $display("%0t: %0d expected output bytes never arrived", $time, frames_due.size());
      end

      $display("Sent %0d requests in %0d messages (%0d produced output) under four idle mixes",
               reqs_sent, msgs_sent, reqs_framed);
      $display("Checked %0d output bytes, %0d of them rejected-message errors",
               bytes_checked, drops_seen);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
